### design/eqs_pkg.sv
// ----------------------------------------------------------------------------
// eqs_pkg
// Shared types and constants for the three-band channel EQ strip.
// ----------------------------------------------------------------------------
package eqs_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int SLOTS        = 2 * NUM_CHANNELS;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int SAMPLE_W  = 24;
    localparam int STATE_W   = 32;          // Q4.28 filter memory
    localparam int COEF_W    = 18;          // Q0.18
    localparam int GAIN_W    = 16;          // Q8.8
    localparam int GAIN_FRAC = 8;
    localparam int OUT_SHIFT = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // shared multiplier and accumulators
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 19;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W;
    localparam int PART_W   = 22;           // band sum split for the output gain
    localparam int YACC_W   = 61;

    localparam logic [2:0] CH_LIMIT = 3'(NUM_CHANNELS);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    localparam logic [CFG_W-1:0] GAIN_UNITY = 64'h0100_0100_0100_0100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_COEF  = 3'd0,
        REG_HIGH_COEF = 3'd1,
        REG_LOW_GAIN  = 3'd2,
        REG_MID_GAIN  = 3'd3,
        REG_HIGH_GAIN = 3'd4,
        REG_OUT_GAIN  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOW_SPLIT  = 4'd1,
        OP_HIGH_SPLIT = 4'd2,
        OP_LOW_BAND   = 4'd3,
        OP_MID_BAND   = 4'd4,
        OP_HIGH_BAND  = 4'd5,
        OP_GAIN_LO    = 4'd6,
        OP_GAIN_HI    = 4'd7,
        OP_FINISH     = 4'd8
    } t_op;

    typedef struct packed {
        logic [1:0]                 channel;
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic                       last_in_block;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic [SAMPLE_W-1:0]        peak_left;
        logic [SAMPLE_W-1:0]        peak_right;
        logic                       peak_valid;
    } t_frame_out;

    typedef struct packed {
        logic load;
        logic clear;
        logic publish;
        logic side;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic ch_ok;
    } t_sts;

endpackage

### design/channel_three_band_eq_strip.sv
// ----------------------------------------------------------------------------
// channel_three_band_eq_strip
// Three-band crossover EQ for up to four stereo mixer channels.
// ----------------------------------------------------------------------------
// One input word is one stereo frame of one channel (Q4.20 samples). Each
// side runs through two one-pole lowpass splits (low = L, mid = H - L,
// high = x - H), the bands are weighted by the channel's Q8.8 gains, the
// sum is scaled by the channel output gain and saturated to the Q4.20
// range. A per-side absolute peak is held per channel and is returned and
// cleared on a word flagged last_in_block. One result word per input word.
// Schedule: a word is accepted, runs 10 steps per side on one shared 34x19
// multiplier with a registered product, and is then moved into the output
// register. The next word is taken as soon as the result sits in the output
// register, so a word is not taken before the last one is through, and a
// consumer that holds off ready stalls the block. Config writes
// land at once and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module channel_three_band_eq_strip import eqs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input word
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_frame_in            i_frame,
    // result word
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_frame_out           o_result
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: handshakes, step schedule, output valid
    eqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // arithmetic, filter memories, peaks, output register
    eqs_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (i_frame),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

endmodule

### design/eqs_ctrl.sv
// ----------------------------------------------------------------------------
// eqs_ctrl
// Sequencer: issues the multiply steps for both sides, owns the handshakes.
// ----------------------------------------------------------------------------
module eqs_ctrl import eqs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_PUB  = 3'b100
    } t_state;

    localparam logic [3:0] LAST_STEP = 4'd9;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_side, n_side;
    logic       r_out_valid, n_out_valid;
    t_op        step_op;

    // step schedule; product of step k is consumed at step k+1
    always_comb begin
        case (r_step)
            4'd0:    step_op = OP_LOW_SPLIT;
            4'd1:    step_op = OP_HIGH_SPLIT;
            4'd2:    step_op = OP_LOW_BAND;
            4'd3:    step_op = OP_MID_BAND;
            4'd4:    step_op = OP_HIGH_BAND;
            4'd6:    step_op = OP_GAIN_LO;
            4'd7:    step_op = OP_GAIN_HI;
            4'd9:    step_op = OP_FINISH;
            default: step_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_side      = r_side;
        n_out_valid = r_out_valid;
        o_cmd       = '{load: 1'b0, clear: 1'b0, publish: 1'b0, side: r_side, op: OP_NONE};

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_side     = 1'b0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.ch_ok) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_PUB;
                end else begin
                    o_cmd.op = step_op;
                    if (r_step == LAST_STEP) begin
                        n_step = '0;
                        if (r_side) begin
                            n_state = S_PUB;
                        end else begin
                            n_side = 1'b1;
                        end
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            S_PUB: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

### design/eqs_datapath.sv
// ----------------------------------------------------------------------------
// eqs_datapath
// Config registers, filter and peak stores, shared multiplier, result regs.
// ----------------------------------------------------------------------------
module eqs_datapath import eqs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_frame_in            i_frame,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_frame_out           o_result
);

    logic [COEF_W-1:0] r_coef_low, r_coef_high;
    logic [CFG_W-1:0]  r_gain_low, r_gain_mid, r_gain_high, r_gain_out;

    logic signed [STATE_W-1:0]  r_sl [SLOTS];
    logic signed [STATE_W-1:0]  r_sh [SLOTS];
    logic        [SAMPLE_W-1:0] r_pk [SLOTS];

    t_frame_in                 r_frame;
    t_op                       r_op_d;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [YACC_W-1:0]  r_yacc;
    t_frame_out                r_res;
    t_frame_out                r_out;

    logic [SLOT_W-1:0]          slot;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [STATE_W-1:0]  xq, sl, sh;
    logic [GAIN_W-1:0]          g_low, g_mid, g_high, g_out;
    logic signed [ACC_W-1:0]    acc_sh;
    logic [PART_W-1:0]          acc_lo;
    logic signed [PART_W-1:0]   acc_hi;
    logic signed [MUL_A_W-1:0]  a_op;
    logic signed [MUL_B_W-1:0]  b_op;
    logic signed [PROD_W-1:0]   prod;
    logic signed [YACC_W-1:0]   y_full;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic [SAMPLE_W-1:0]        mag, pk_new;

    assign o_sts.ch_ok = ({1'b0, r_frame.channel} < CH_LIMIT);

    assign slot   = SLOT_W'({r_frame.channel, i_cmd.side});
    assign x      = i_cmd.side ? r_frame.in_right : r_frame.in_left;
    assign xq     = {x, 8'b0};
    assign sl     = r_sl[slot];
    assign sh     = r_sh[slot];
    assign g_low  = r_gain_low [GAIN_W*r_frame.channel +: GAIN_W];
    assign g_mid  = r_gain_mid [GAIN_W*r_frame.channel +: GAIN_W];
    assign g_high = r_gain_high[GAIN_W*r_frame.channel +: GAIN_W];
    assign g_out  = r_gain_out [GAIN_W*r_frame.channel +: GAIN_W];

    // band sum in Q.28, split so the output gain fits the shared multiplier
    assign acc_sh = r_acc >>> GAIN_FRAC;
    assign acc_lo = acc_sh[PART_W-1:0];
    assign acc_hi = acc_sh[2*PART_W-1:PART_W];

    always_comb begin
        case (i_cmd.op)
            OP_LOW_SPLIT: begin
                a_op = MUL_A_W'(xq) - MUL_A_W'(sl);
                b_op = MUL_B_W'({1'b0, r_coef_low});
            end
            OP_HIGH_SPLIT: begin
                a_op = MUL_A_W'(xq) - MUL_A_W'(sh);
                b_op = MUL_B_W'({1'b0, r_coef_high});
            end
            OP_LOW_BAND: begin
                a_op = MUL_A_W'(sl);
                b_op = MUL_B_W'({1'b0, g_low});
            end
            OP_MID_BAND: begin
                a_op = MUL_A_W'(sh) - MUL_A_W'(sl);
                b_op = MUL_B_W'({1'b0, g_mid});
            end
            OP_HIGH_BAND: begin
                a_op = MUL_A_W'(xq) - MUL_A_W'(sh);
                b_op = MUL_B_W'({1'b0, g_high});
            end
            OP_GAIN_LO: begin
                a_op = MUL_A_W'({1'b0, acc_lo});
                b_op = MUL_B_W'({1'b0, g_out});
            end
            OP_GAIN_HI: begin
                a_op = MUL_A_W'(acc_hi);
                b_op = MUL_B_W'({1'b0, g_out});
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign prod = a_op * b_op;

    // output scaling, saturation and peak
    always_comb begin
        y_full = r_yacc >>> OUT_SHIFT;
        if (y_full > YACC_W'(SAMPLE_MAX)) begin
            y_sat = SAMPLE_MAX;
        end else if (y_full < YACC_W'(SAMPLE_MIN)) begin
            y_sat = SAMPLE_MIN;
        end else begin
            y_sat = y_full[SAMPLE_W-1:0];
        end
        mag    = y_sat[SAMPLE_W-1] ? SAMPLE_W'(-y_sat) : SAMPLE_W'(y_sat);
        pk_new = (mag > r_pk[slot]) ? mag : r_pk[slot];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_low  <= '0;
            r_coef_high <= '0;
            r_gain_low  <= GAIN_UNITY;
            r_gain_mid  <= GAIN_UNITY;
            r_gain_high <= GAIN_UNITY;
            r_gain_out  <= GAIN_UNITY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_COEF:  r_coef_low  <= i_cfg_data[COEF_W-1:0];
                REG_HIGH_COEF: r_coef_high <= i_cfg_data[COEF_W-1:0];
                REG_LOW_GAIN:  r_gain_low  <= i_cfg_data;
                REG_MID_GAIN:  r_gain_mid  <= i_cfg_data;
                REG_HIGH_GAIN: r_gain_high <= i_cfg_data;
                REG_OUT_GAIN:  r_gain_out  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_sl[i] <= '0;
                r_sh[i] <= '0;
                r_pk[i] <= '0;
            end
            r_op_d <= OP_NONE;
        end else begin
            r_op_d <= i_cmd.op;
            if (r_op_d == OP_LOW_SPLIT) begin
                r_sl[slot] <= sl + STATE_W'(r_prod >>> COEF_W);
            end
            if (r_op_d == OP_HIGH_SPLIT) begin
                r_sh[slot] <= sh + STATE_W'(r_prod >>> COEF_W);
            end
            if (i_cmd.op == OP_FINISH) begin
                r_pk[slot] <= r_frame.last_in_block ? '0 : pk_new;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_cmd.load) begin
            r_frame <= i_frame;
        end
        case (r_op_d)
            OP_LOW_BAND:  r_acc  <= ACC_W'(r_prod);
            OP_MID_BAND:  r_acc  <= r_acc + ACC_W'(r_prod);
            OP_HIGH_BAND: r_acc  <= r_acc + ACC_W'(r_prod);
            OP_GAIN_LO:   r_yacc <= YACC_W'(r_prod);
            OP_GAIN_HI:   r_yacc <= r_yacc + (YACC_W'(r_prod) <<< PART_W);
            default: ;
        endcase
        if (i_cmd.clear) begin
            r_res <= '0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_res.peak_valid <= r_frame.last_in_block;
            if (i_cmd.side) begin
                r_res.out_right  <= y_sat;
                r_res.peak_right <= r_frame.last_in_block ? pk_new : '0;
            end else begin
                r_res.out_left  <= y_sat;
                r_res.peak_left <= r_frame.last_in_block ? pk_new : '0;
            end
        end
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    assign o_result = r_out;

endmodule

### bench/channel_three_band_eq_strip_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_three_band_eq_strip_tb
// Self-checking bench for the three-band channel EQ strip.
// ----------------------------------------------------------------------------
// Frames are driven on the input valid/ready port and every accepted frame
// runs through a bit-true predictor of the split filters, band gains,
// output gain, saturation and block peaks. The expected result word is
// queued and compared field by field with each word taken from the output
// port. Directed cases cover the reset gains, the register extremes,
// positive and negative saturation, killed bands, a muted channel, writes
// to unused register indexes and peak publishing. One long output stall then
// backs the block up into its input, and random traffic runs under three
// idle patterns and several register settings.
// ----------------------------------------------------------------------------
module channel_three_band_eq_strip_tb import eqs_pkg::*;;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;   // long output stall
    // No word may go this long without a handshake on either port. The
    // slowest correct stretch is the long stall plus one word's processing.
    localparam int QUIET_LIMIT   = 4000;
    localparam int ITEMS_PER_SET = 79;    // 3 idle modes x 4 settings

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    t_frame_in            i_frame;
    logic                 o_valid;
    logic                 i_ready;
    t_frame_out           o_result;

    channel_three_band_eq_strip dut (.*);

    // ------------------------------------------------------------------------
    // Predictor state: register copies and per-slot filter / peak memory.
    // Slot = channel*2 + side (0 left, 1 right).
    // ------------------------------------------------------------------------
    logic [COEF_W-1:0]   low_coef, high_coef;
    logic [CFG_W-1:0]    low_gains, mid_gains, high_gains, strip_gains;
    longint              low_mem  [SLOTS];   // Q4.28
    longint              high_mem [SLOTS];
    logic [SAMPLE_W-1:0] peak_hold[SLOTS];

    t_frame_out eq_frames_due[$];            // predicted result words, oldest first

    int  mismatch_count = 0;
    int  src_idle_pct   = 38;
    int  snk_idle_pct   = 69;
    int  quiet_cycles   = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int  hold_left      = 0;

    // ------------------------------------------------------------------------
    // Clock and all input defaults
    // ------------------------------------------------------------------------
    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_frame    = '0;
        i_ready    = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint gain_at(input logic [CFG_W-1:0] packed_g, input int ch);
        return longint'(packed_g[GAIN_W*ch +: GAIN_W]);
    endfunction

    // One side of one channel: both splits advance, then the three bands are
    // weighted, scaled by the output gain and clipped to Q4.20.
    // >>> on a signed longint floors toward minus infinity, as the block does.
    function automatic longint eq_side(input int slot, input int ch, input longint x);
        longint xq, lo, hi, acc, y;
        xq = x * 256;
        low_mem[slot]  += (longint'(low_coef)  * (xq - low_mem[slot]))  >>> COEF_W;
        high_mem[slot] += (longint'(high_coef) * (xq - high_mem[slot])) >>> COEF_W;
        lo  = low_mem[slot];
        hi  = high_mem[slot];
        acc = lo * gain_at(low_gains, ch)
            + (hi - lo) * gain_at(mid_gains, ch)
            + (xq - hi) * gain_at(high_gains, ch);
        acc = acc >>> GAIN_FRAC;
        y   = (acc * gain_at(strip_gains, ch)) >>> OUT_SHIFT;
        if (y > longint'(SAMPLE_MAX))
            y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN))
            y = longint'(SAMPLE_MIN);
        return y;
    endfunction

    function automatic t_frame_out eq_strip_frame(input t_frame_in f);
        t_frame_out          r;
        longint              y [2];
        logic [SAMPLE_W-1:0] pk[2];
        logic [SAMPLE_W-1:0] mag;
        int                  ch, slot, side;
        r  = '0;
        ch = f.channel;
        if (ch >= NUM_CHANNELS)
            return r;                        // frame dropped, all-zero result
        y[0] = eq_side(2 * ch, ch, longint'(f.in_left));
        y[1] = eq_side(2 * ch + 1, ch, longint'(f.in_right));
        for (side = 0; side < 2; side++) begin
            slot = 2 * ch + side;
            mag  = SAMPLE_W'((y[side] < 0) ? -y[side] : y[side]);
            if (mag > peak_hold[slot])
                peak_hold[slot] = mag;
            pk[side] = peak_hold[slot];
            if (f.last_in_block)
                peak_hold[slot] = '0;
        end
        r.out_left  = y[0][SAMPLE_W-1:0];
        r.out_right = y[1][SAMPLE_W-1:0];
        if (f.last_in_block) begin
            r.peak_left  = pk[0];
            r.peak_right = pk[1];
            r.peak_valid = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(15))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic t_frame_in rand_frame();
        t_frame_in f;
        f.channel       = 2'($urandom_range(3));
        f.in_left       = rand_sample();
        f.in_right      = rand_sample();
        f.last_in_block = ($urandom_range(9) == 0);
        return f;
    endfunction

    // mostly audio-like small coefficients, sometimes anything
    function automatic logic [CFG_W-1:0] rand_coef();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_W'(262143);
            2, 3:    return CFG_W'($urandom_range(262143));
            default: return CFG_W'($urandom_range(20000));
        endcase
    endfunction

    // per channel: killed, full range, or near unity
    function automatic logic [CFG_W-1:0] rand_gains();
        logic [CFG_W-1:0] g;
        int               ch;
        for (ch = 0; ch < 4; ch++) begin
            case ($urandom_range(7))
                0:       g[GAIN_W*ch +: GAIN_W] = '0;
                1:       g[GAIN_W*ch +: GAIN_W] = GAIN_W'($urandom());
                default: g[GAIN_W*ch +: GAIN_W] = GAIN_W'($urandom_range(16'h0200));
            endcase
        end
        return g;
    endfunction

    // ------------------------------------------------------------------------
    // Register writes; the predictor copy follows at the write edge.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LOW_COEF:  low_coef    = value[COEF_W-1:0];
            REG_HIGH_COEF: high_coef   = value[COEF_W-1:0];
            REG_LOW_GAIN:  low_gains   = value;
            REG_MID_GAIN:  mid_gains   = value;
            REG_HIGH_GAIN: high_gains  = value;
            REG_OUT_GAIN:  strip_gains = value;
            default: ;                       // unused index, ignored
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] lc, input logic [CFG_W-1:0] hc,
                               input logic [CFG_W-1:0] lg, input logic [CFG_W-1:0] mg,
                               input logic [CFG_W-1:0] hg, input logic [CFG_W-1:0] og);
        write_reg(REG_LOW_COEF,  lc);
        write_reg(REG_HIGH_COEF, hc);
        write_reg(REG_LOW_GAIN,  lg);
        write_reg(REG_MID_GAIN,  mg);
        write_reg(REG_HIGH_GAIN, hg);
        write_reg(REG_OUT_GAIN,  og);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Valid stays up from one word to the next when no idle cycle is
    // drawn, so it is never dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_frame(input t_frame_in f);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_frame <= f;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        eq_frames_due.push_back(eq_strip_frame(f));
    endtask

    // Drop valid, let every predicted word come back, then let the pipe empty.
    task automatic settle();
        i_valid <= 1'b0;
        while (eq_frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_frame_in make_frame(input int ch, input logic [SAMPLE_W-1:0] l,
                                             input logic [SAMPLE_W-1:0] r, input logic last);
        t_frame_in f;
        f.channel       = 2'(ch);
        f.in_left       = l;
        f.in_right      = r;
        f.last_in_block = last;
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver ready: random stalls, or one long counted hold when asked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left + 1;
            if (hold_left == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            if (!hold_req) begin
                hold_done <= 1'b0;
                hold_left <= 0;
            end
            i_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (eq_frames_due.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: %h", o_result));
            end else begin
                want = eq_frames_due.pop_front();
                if (o_result.out_left !== want.out_left)
                    report_mismatch($sformatf("out_left got %h want %h",
                                              o_result.out_left, want.out_left));
                if (o_result.out_right !== want.out_right)
                    report_mismatch($sformatf("out_right got %h want %h",
                                              o_result.out_right, want.out_right));
                if (o_result.peak_left !== want.peak_left)
                    report_mismatch($sformatf("peak_left got %h want %h",
                                              o_result.peak_left, want.peak_left));
                if (o_result.peak_right !== want.peak_right)
                    report_mismatch($sformatf("peak_right got %h want %h",
                                              o_result.peak_right, want.peak_right));
                if (o_result.peak_valid !== want.peak_valid)
                    report_mismatch($sformatf("peak_valid got %b want %b",
                                              o_result.peak_valid, want.peak_valid));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a handshake on either port ends the run.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset gains are unity and both coefficients zero, so L = H = 0 and the
    // output is the input itself. Peaks include the full-scale negative one.
    task automatic test_reset_values();
        send_frame(make_frame(0, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
        send_frame(make_frame(1, '0, '1, 1'b0));
        send_frame(make_frame(2, 24'h000001, 24'h800001, 1'b0));
        send_frame(make_frame(3, 24'h123456, 24'hABCDEF, 1'b1));
        send_frame(make_frame(0, 24'h000010, 24'hFFFFF0, 1'b1));
    endtask

    // Register extremes: coefficients and gains all ones saturate both ways;
    // then killed bands, a muted channel and writes to unused indexes.
    task automatic test_register_extremes();
        settle();
        load_config(CFG_W'(262143), CFG_W'(262143), '1, '1, '1, '1);
        send_frame(make_frame(0, SAMPLE_MAX, 24'h000400, 1'b0));
        send_frame(make_frame(1, SAMPLE_MIN, 24'hFFFC00, 1'b0));
        send_frame(make_frame(0, 24'h080000, SAMPLE_MIN, 1'b1));
        settle();
        // low band killed, high band halved, channel 2 muted
        load_config('0, CFG_W'(300), '0, GAIN_UNITY,
                    64'h0080_0080_0080_0080, 64'h0100_0000_0100_0100);
        write_reg(REG_SPARE_6, {$urandom(), $urandom()});
        write_reg(REG_SPARE_7, {$urandom(), $urandom()});
        send_frame(make_frame(0, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
        send_frame(make_frame(1, rand_sample(), rand_sample(), 1'b0));
        send_frame(make_frame(2, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
        send_frame(make_frame(3, rand_sample(), rand_sample(), 1'b1));
    endtask

    // Peak handling: a multi-word block interleaved with another channel, a
    // one-word block, and a block that starts right after a publish.
    task automatic test_peak_publish();
        settle();
        load_config(CFG_W'(2000), CFG_W'(40000), 64'h0180_0200_00C0_0100,
                    64'h0100_00C0_0180_0100, 64'h0040_0100_0100_0200,
                    64'h0100_0180_0100_00C0);
        send_frame(make_frame(1, 24'h300000, 24'hD00000, 1'b0));
        send_frame(make_frame(1, 24'h100000, 24'hF00000, 1'b0));
        send_frame(make_frame(3, 24'h7FFF00, 24'h800100, 1'b1));
        send_frame(make_frame(1, 24'hE00000, 24'h200000, 1'b0));
        send_frame(make_frame(1, 24'h000000, 24'h000000, 1'b1));
        send_frame(make_frame(1, 24'h010000, 24'hFF0000, 1'b1));
        send_frame(make_frame(0, SAMPLE_MIN, SAMPLE_MIN, 1'b1));
    endtask

    // Output held off for a long counted stretch while words keep coming:
    // the block fills, drops its ready, and resumes when the hold ends.
    task automatic test_output_stall();
        int n;
        hold_req <= 1'b1;
        for (n = 0; n < 12; n++)
            send_frame(rand_frame());
        hold_req <= 1'b0;
    endtask

    // Random traffic under each idle pattern, several register settings each.
    task automatic test_random_traffic();
        int src_pct[3] = '{38, 69, 0};
        int snk_pct[3] = '{69, 38, 0};
        int mode, set, n;
        for (mode = 0; mode < 3; mode++) begin
            for (set = 0; set < 4; set++) begin
                settle();
                src_idle_pct = src_pct[mode];
                snk_idle_pct = snk_pct[mode];
                load_config(rand_coef(), rand_coef(), rand_gains(), rand_gains(),
                            rand_gains(), rand_gains());
                for (n = 0; n < ITEMS_PER_SET; n++)
                    send_frame(rand_frame());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int s;
        // predictor matches the block's reset state
        low_coef    = '0;
        high_coef   = '0;
        low_gains   = GAIN_UNITY;
        mid_gains   = GAIN_UNITY;
        high_gains  = GAIN_UNITY;
        strip_gains = GAIN_UNITY;
        for (s = 0; s < SLOTS; s++) begin
            low_mem[s]   = 0;
            high_mem[s]  = 0;
            peak_hold[s] = '0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_register_extremes();
        test_peak_publish();
        test_output_stall();
        test_random_traffic();

        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
design/eqs_pkg.sv
design/eqs_ctrl.sv
design/eqs_datapath.sv
design/channel_three_band_eq_strip.sv
bench/channel_three_band_eq_strip_tb.sv
